// ===== src/amf_pkg.sv =====
// ----------------------------------------------------------------------------
// Adaptive median filter package
// Shared widths, register indexes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package amf_pkg;

   localparam int PIX_W      = 8;
   localparam int COL_W      = 11;
   localparam int HGT_W      = 13;
   localparam int MWIN_W     = 3;
   localparam int CSR_W      = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int MAX_HEIGHT = 4096;
   localparam int BIT_W      = 3;

   localparam logic [COL_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
   localparam logic [HGT_W-1:0]  RST_FRAME_HEIGHT = 13'd480;
   localparam logic [MWIN_W-1:0] RST_MAX_WINDOW   = 3'd7;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WINDOW   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MM_INIT,
      ST_MM_SCAN,
      ST_MM_DRAIN,
      ST_BS_INIT,
      ST_BS_SCAN,
      ST_BS_DRAIN,
      ST_BS_EVAL,
      ST_WIN_EVAL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic write_px;
      logic win_first;
      logic win_next;
      logic scan_init;
      logic mm_clear;
      logic issue_mm;
      logic issue_cnt;
      logic bs_start;
      logic bs_clear;
      logic bs_update;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic in_done;
      logic emit_due;
      logic scan_last;
      logic count_le_k;
      logic bit_zero;
      logic win_pass;
      logic win_last;
      logic out_free;
   } status_type;

endpackage

// ===== src/amf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Adaptive median filter controller
// Sequences item intake, the window scans and the median bisection passes.
// ----------------------------------------------------------------------------
module amf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_flush,
   input  amf_pkg::status_type status,
   output amf_pkg::cmd_type    cmd
);

   amf_pkg::state_type state_ff;
   amf_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= amf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         amf_pkg::ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               if (status.in_done) begin
                  cmd.win_first = 1'b1;
                  state_in      = amf_pkg::ST_MM_INIT;
               end else if (!req_flush) begin
                  cmd.write_px = 1'b1;
                  state_in     = amf_pkg::ST_CHECK;
               end
            end
         end
         amf_pkg::ST_CHECK: begin
            if (status.emit_due) begin
               cmd.win_first = 1'b1;
               state_in      = amf_pkg::ST_MM_INIT;
            end else begin
               state_in = amf_pkg::ST_IDLE;
            end
         end
         amf_pkg::ST_MM_INIT: begin
            cmd.scan_init = 1'b1;
            cmd.mm_clear  = 1'b1;
            state_in      = amf_pkg::ST_MM_SCAN;
         end
         amf_pkg::ST_MM_SCAN: begin
            cmd.issue_mm = 1'b1;
            if (status.scan_last) begin
               state_in = amf_pkg::ST_MM_DRAIN;
            end
         end
         amf_pkg::ST_MM_DRAIN: begin
            cmd.bs_start = 1'b1;
            state_in     = amf_pkg::ST_BS_INIT;
         end
         amf_pkg::ST_BS_INIT: begin
            cmd.scan_init = 1'b1;
            cmd.bs_clear  = 1'b1;
            state_in      = amf_pkg::ST_BS_SCAN;
         end
         amf_pkg::ST_BS_SCAN: begin
            cmd.issue_cnt = 1'b1;
            if (status.scan_last) begin
               state_in = amf_pkg::ST_BS_DRAIN;
            end
         end
         amf_pkg::ST_BS_DRAIN: begin
            state_in = amf_pkg::ST_BS_EVAL;
         end
         amf_pkg::ST_BS_EVAL: begin
            cmd.bs_update = 1'b1;
            if (status.bit_zero) begin
               state_in = amf_pkg::ST_WIN_EVAL;
            end else begin
               state_in = amf_pkg::ST_BS_INIT;
            end
         end
         amf_pkg::ST_WIN_EVAL: begin
            if (status.win_pass || status.win_last) begin
               state_in = amf_pkg::ST_DONE;
            end else begin
               cmd.win_next = 1'b1;
               state_in     = amf_pkg::ST_MM_INIT;
            end
         end
         amf_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = amf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = amf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/amf_dp.sv =====
// ----------------------------------------------------------------------------
// Adaptive median filter datapath
// Line memory, frame counters, window scan addressing, min/max and median
// bisection accumulators, configuration registers and the output register.
// ----------------------------------------------------------------------------
module amf_dp #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_WIN   = 7
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [amf_pkg::PIX_W-1:0]            req_pixel,
   input  logic                                 csr_wr_en,
   input  logic [amf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [amf_pkg::CSR_W-1:0]            csr_wdata,
   input  amf_pkg::cmd_type                     cmd,
   output amf_pkg::status_type                  status,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [amf_pkg::PIX_W-1:0]            rsp_pixel,
   output logic                                 rsp_last
);

   localparam int DEPTH  = (MAX_WIN - 1) * MAX_WIDTH + MAX_WIN;
   localparam int AW     = $clog2(DEPTH);
   localparam int OFF_W  = AW + 1;
   localparam int SW     = AW + 2;
   localparam int RW     = $clog2(MAX_WIN);
   localparam int TOP_R  = (MAX_WIN - 1) / 2;
   localparam int NW     = $clog2(MAX_WIN * MAX_WIN + 1);
   localparam int RS     = amf_pkg::HGT_W + 2;
   localparam int CS     = amf_pkg::COL_W + 2;
   localparam int CW     = amf_pkg::COL_W;
   localparam int HW     = amf_pkg::HGT_W;
   localparam int PW     = amf_pkg::PIX_W;

   // Configuration registers.
   logic [CW-1:0]                  frame_width_ff;
   logic [HW-1:0]                  frame_height_ff;
   logic [amf_pkg::MWIN_W-1:0]     max_window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= amf_pkg::RST_FRAME_WIDTH;
         frame_height_ff <= amf_pkg::RST_FRAME_HEIGHT;
         max_window_ff   <= amf_pkg::RST_MAX_WINDOW;
      end else if (csr_wr_en) begin
         case (csr_index)
            amf_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[CW-1:0];
            amf_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[HW-1:0];
            amf_pkg::CSR_MAX_WINDOW:   max_window_ff   <= csr_wdata[amf_pkg::MWIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamped geometry seen at frame start.
   logic [CW-1:0]                  fw_cl;
   logic [HW-1:0]                  fh_cl;
   logic [amf_pkg::MWIN_W-1:0]     mw3;
   logic [amf_pkg::MWIN_W-1:0]     rad_raw;
   logic [RW-1:0]                  rad_cl;
   logic [AW-1:0]                  flag_cl;

   always_comb begin
      if (frame_width_ff == '0) begin
         fw_cl = CW'(1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         fw_cl = CW'(MAX_WIDTH);
      end else begin
         fw_cl = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         fh_cl = HW'(1);
      end else if (32'(frame_height_ff) > amf_pkg::MAX_HEIGHT) begin
         fh_cl = HW'(amf_pkg::MAX_HEIGHT);
      end else begin
         fh_cl = frame_height_ff;
      end
      mw3     = (max_window_ff < 3'd3) ? 3'd3 : max_window_ff;
      rad_raw = (mw3 - 3'd1) >> 1;
      if (32'(rad_raw) > TOP_R) begin
         rad_cl = RW'(TOP_R);
      end else begin
         rad_cl = RW'(rad_raw);
      end
      flag_cl = AW'(AW'(rad_cl) * AW'(fw_cl) + AW'(rad_cl));
   end

   // Frame state.
   logic                 active_ff;
   logic                 in_done_ff;
   logic [CW-1:0]        fw_ff;
   logic [HW-1:0]        fh_ff;
   logic [RW-1:0]        rad_ff;
   logic [AW-1:0]        flag_ff;
   logic [CW-1:0]        in_col_ff;
   logic [HW-1:0]        in_row_ff;
   logic [CW-1:0]        out_col_ff;
   logic [HW-1:0]        out_row_ff;
   logic [AW-1:0]        wr_ptr_ff;
   logic [AW-1:0]        out_ptr_ff;
   logic [AW:0]          pending_ff;

   logic [CW-1:0]        fw_cur;
   logic [HW-1:0]        fh_cur;
   logic [CW-1:0]        in_col_inc;
   logic [HW-1:0]        in_row_inc;
   logic [CW-1:0]        out_col_inc;
   logic [HW-1:0]        out_row_inc;
   logic                 out_wrap;
   logic                 frame_done;

   assign fw_cur      = active_ff ? fw_ff : fw_cl;
   assign fh_cur      = active_ff ? fh_ff : fh_cl;
   assign in_col_inc  = in_col_ff + CW'(1);
   assign in_row_inc  = in_row_ff + HW'(1);
   assign out_col_inc = out_col_ff + CW'(1);
   assign out_row_inc = out_row_ff + HW'(1);
   assign out_wrap    = out_col_inc >= fw_ff;
   assign frame_done  = out_wrap && (out_row_inc >= fh_ff);

   // Window scan state and result accumulators.
   logic [RW-1:0]              x_ff;
   logic signed [RW:0]         dr_ff;
   logic signed [RW:0]         dc_ff;
   logic signed [OFF_W-1:0]    row_off_ff;
   logic [PW-1:0]              lo_ff;
   logic [PW-1:0]              hi_ff;
   logic [PW-1:0]              center_ff;
   logic [NW-1:0]              cnt_ff;
   logic [NW-1:0]              lt_ff;
   logic [amf_pkg::BIT_W-1:0]  bit_ff;
   logic [PW-1:0]              res_ff;
   logic                       vld_d_ff;
   logic                       mm_d_ff;
   logic                       ctr_d_ff;
   logic [PW-1:0]              rd_data_ff;
   logic                       rsp_valid_ff;
   logic [PW-1:0]              rsp_pixel_ff;
   logic                       rsp_last_ff;

   logic signed [RW:0]         xs;
   logic [OFF_W-1:0]           xprod;
   logic signed [SW-1:0]       addr_sum;
   logic signed [SW-1:0]       addr_fix;
   logic [AW-1:0]              rd_addr;
   logic signed [RS-1:0]       rr;
   logic signed [CS-1:0]       cc;
   logic                       inimg;
   logic                       issue;
   logic [PW-1:0]              trial;
   logic                       center_in;
   logic [PW-1:0]              out_val;

   assign xs    = $signed({1'b0, x_ff});
   assign xprod = OFF_W'(OFF_W'(x_ff) * OFF_W'(fw_ff));
   assign issue = cmd.issue_mm || cmd.issue_cnt;
   assign trial = res_ff | (PW'(1) << bit_ff);

   always_comb begin
      addr_sum = $signed(SW'(out_ptr_ff)) + SW'(row_off_ff) + SW'(dc_ff);
      if (addr_sum < 0) begin
         addr_fix = addr_sum + $signed(SW'(DEPTH));
      end else if (addr_sum >= $signed(SW'(DEPTH))) begin
         addr_fix = addr_sum - $signed(SW'(DEPTH));
      end else begin
         addr_fix = addr_sum;
      end
      rd_addr = addr_fix[AW-1:0];
      rr      = $signed(RS'(out_row_ff)) + RS'(dr_ff);
      cc      = $signed(CS'(out_col_ff)) + CS'(dc_ff);
      inimg   = (rr >= 0) && (rr < $signed(RS'(fh_ff)))
                && (cc >= 0) && (cc < $signed(CS'(fw_ff)));
   end

   // Line memory.
   logic [PW-1:0] line_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (cmd.write_px) begin
         line_mem[wr_ptr_ff] <= req_pixel;
      end
      rd_data_ff <= line_mem[rd_addr];
   end

   // Frame counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         in_done_ff <= 1'b0;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         wr_ptr_ff  <= '0;
         out_ptr_ff <= '0;
         pending_ff <= '0;
         fw_ff      <= amf_pkg::RST_FRAME_WIDTH;
         fh_ff      <= amf_pkg::RST_FRAME_HEIGHT;
         rad_ff     <= RW'(TOP_R);
         flag_ff    <= '0;
      end else if (cmd.write_px) begin
         if (!active_ff) begin
            active_ff <= 1'b1;
            fw_ff     <= fw_cl;
            fh_ff     <= fh_cl;
            rad_ff    <= rad_cl;
            flag_ff   <= flag_cl;
         end
         if (in_col_inc >= fw_cur) begin
            in_col_ff <= '0;
            in_row_ff <= in_row_inc;
            if (in_row_inc >= fh_cur) begin
               in_done_ff <= 1'b1;
            end
         end else begin
            in_col_ff <= in_col_inc;
         end
         wr_ptr_ff  <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         pending_ff <= pending_ff + (AW + 1)'(1);
      end else if (cmd.load_out) begin
         if (frame_done) begin
            active_ff  <= 1'b0;
            in_done_ff <= 1'b0;
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
            wr_ptr_ff  <= '0;
            out_ptr_ff <= '0;
            pending_ff <= '0;
         end else begin
            if (out_wrap) begin
               out_col_ff <= '0;
               out_row_ff <= out_row_inc;
            end else begin
               out_col_ff <= out_col_inc;
            end
            out_ptr_ff <= (out_ptr_ff == AW'(DEPTH - 1)) ? '0 : out_ptr_ff + AW'(1);
            pending_ff <= pending_ff - (AW + 1)'(1);
         end
      end
   end

   // Window scan and accumulation.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_d_ff <= 1'b0;
         mm_d_ff  <= 1'b0;
         ctr_d_ff <= 1'b0;
      end else begin
         vld_d_ff <= issue && inimg;
         mm_d_ff  <= cmd.issue_mm;
         ctr_d_ff <= (dr_ff == 0) && (dc_ff == 0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.win_first) begin
         x_ff <= RW'(1);
      end else if (cmd.win_next) begin
         x_ff <= x_ff + RW'(1);
      end
      if (cmd.scan_init) begin
         dr_ff      <= -xs;
         dc_ff      <= -xs;
         row_off_ff <= -$signed(xprod);
      end else if (issue) begin
         if (dc_ff == xs) begin
            dc_ff      <= -xs;
            dr_ff      <= dr_ff + (RW + 1)'(1);
            row_off_ff <= row_off_ff + $signed(OFF_W'(fw_ff));
         end else begin
            dc_ff <= dc_ff + (RW + 1)'(1);
         end
      end
      if (cmd.mm_clear) begin
         lo_ff  <= '1;
         hi_ff  <= '0;
         cnt_ff <= '0;
      end else if (vld_d_ff && mm_d_ff) begin
         if (rd_data_ff < lo_ff) begin
            lo_ff <= rd_data_ff;
         end
         if (rd_data_ff > hi_ff) begin
            hi_ff <= rd_data_ff;
         end
         cnt_ff <= cnt_ff + NW'(1);
         if (ctr_d_ff) begin
            center_ff <= rd_data_ff;
         end
      end
      if (cmd.bs_clear) begin
         lt_ff <= '0;
      end else if (vld_d_ff && !mm_d_ff && (rd_data_ff < trial)) begin
         lt_ff <= lt_ff + NW'(1);
      end
      if (cmd.bs_start) begin
         bit_ff <= amf_pkg::BIT_W'(PW - 1);
         res_ff <= '0;
      end else if (cmd.bs_update) begin
         if (status.count_le_k) begin
            res_ff <= trial;
         end
         bit_ff <= bit_ff - amf_pkg::BIT_W'(1);
      end
   end

   assign center_in = (center_ff > lo_ff) && (center_ff < hi_ff);
   assign out_val   = (status.win_pass && center_in) ? center_ff : res_ff;

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         rsp_pixel_ff <= out_val;
         rsp_last_ff  <= frame_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_pixel  = rsp_pixel_ff;
   assign rsp_last   = rsp_last_ff;

   always_comb begin
      status.in_done    = in_done_ff;
      status.emit_due   = pending_ff > {1'b0, flag_ff};
      status.scan_last  = (dr_ff == xs) && (dc_ff == xs);
      status.count_le_k = lt_ff <= (cnt_ff >> 1);
      status.bit_zero   = bit_ff == '0;
      status.win_pass   = (res_ff > lo_ff) && (res_ff < hi_ff);
      status.win_last   = x_ff == rad_ff;
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

endmodule

// ===== src/adaptive_median_filter.sv =====
// ----------------------------------------------------------------------------
// Adaptive median filter
// Streams 8-bit grayscale pixels in raster order and returns each pixel
// filtered by an adaptive median over windows of side 3 up to max_window.
//
// Usage: pixels enter on the req_ channel (tuser high marks a flush item that
// carries no pixel), filtered pixels leave on the rsp_ channel with tlast on
// the last pixel of the frame. Geometry and window size are written through
// the csr_ port; the user must write them only while the block is idle, which
// the block itself does not enforce, and they take effect at the next frame.
// Results trail their inputs by R rows plus R pixels (R is the largest window
// radius); after the last pixel of a frame, one flush item drains each
// remaining result. The line memory has a single read port; for each window
// side tried it is scanned once for min and max and 8 times for the
// bit-by-bit median search. Reset clears the frame counters and restores
// the default configuration; the scan accumulators and the line memory are
// not cleared. When the receiver stalls, the result waits in the output
// register; the next item is still taken, and its result is held in the
// datapath until the register frees.
// ----------------------------------------------------------------------------
module adaptive_median_filter #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_WIN   = 7
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // pixel
   input  logic                           req_tuser,   // flush
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // out_pixel
   output logic                           rsp_tlast,   // frame_end
   input  logic                           csr_wr_en,
   input  logic [amf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [amf_pkg::CSR_W-1:0]      csr_wdata
);

   amf_pkg::cmd_type    cmd;
   amf_pkg::status_type status;

   amf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_flush  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   amf_dp #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_WIN   (MAX_WIN)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_pixel  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_pixel  (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

endmodule

// ===== bench/adaptive_median_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive median filter testbench
// Streams small frames through the filter under random idling on both sides
// and compares every filtered pixel and frame-end flag against a behavioral
// model of the adaptive median kept inside the bench.
// ----------------------------------------------------------------------------
module adaptive_median_filter_tb;

   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 1000;

   typedef struct {
      logic [7:0] pix;
      logic       last;
   } filt_px_type;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [7:0]                    req_tdata;   // pixel
   logic                          req_tuser;   // flush
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [7:0]                    rsp_tdata;   // out_pixel
   logic                          rsp_tlast;   // frame_end
   logic                          csr_wr_en;
   logic [amf_pkg::CSR_IDX_W-1:0] csr_index;
   logic [amf_pkg::CSR_W-1:0]     csr_wdata;

   adaptive_median_filter dut (.*);

   filt_px_type filt_q[$];
   int         mismatches = 0;
   int         items_sent = 0;
   int         idle_cycles = 0;
   int         rsp_hold = 0;
   bit         rsp_jitter = 1;
   bit         req_jitter = 1;

   // Filter model state.
   int         reg_width = int'(amf_pkg::RST_FRAME_WIDTH);
   int         reg_height = int'(amf_pkg::RST_FRAME_HEIGHT);
   int         reg_window = int'(amf_pkg::RST_MAX_WINDOW);
   int         lat_w, lat_h, lat_side, lag;
   int         in_cnt, out_cnt;
   bit         in_frame = 0;
   bit         draining = 0;
   logic [7:0] img[];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] median_at(int r, int c);
      logic [7:0] win[$];
      int x, n, rr, cc, lo, hi, mid, ctr, v;
      ctr = int'(img[r * lat_w + c]);
      mid = 0;
      for (n = 3; n <= lat_side; n += 2) begin
         x = (n - 1) / 2;
         win.delete();
         lo = 255;
         hi = 0;
         for (rr = r - x; rr <= r + x; rr++) begin
            if (rr < 0 || rr >= lat_h) continue;
            for (cc = c - x; cc <= c + x; cc++) begin
               if (cc < 0 || cc >= lat_w) continue;
               v = int'(img[rr * lat_w + cc]);
               win = {win, img[rr * lat_w + cc]};
               if (v < lo) lo = v;
               if (v > hi) hi = v;
            end
         end
         win.sort();
         mid = int'(win[win.size() / 2]);
         if (mid > lo && mid < hi) return (ctr > lo && ctr < hi) ? ctr[7:0] : mid[7:0];
      end
      return mid[7:0];
   endfunction

   function automatic void emit_filtered();
      filt_px_type e;
      e.pix = median_at(out_cnt / lat_w, out_cnt % lat_w);
      out_cnt++;
      e.last = (out_cnt == lat_w * lat_h);
      if (e.last) begin
         in_frame = 0;
         draining = 0;
      end
      filt_q = {filt_q, e};
   endfunction

   function automatic void filter_accept(logic [7:0] pix, logic flush);
      if (draining) begin
         emit_filtered();
         return;
      end
      if (flush) return;
      if (!in_frame) begin
         lat_w = (reg_width < 1) ? 1 : (reg_width > 1024) ? 1024 : reg_width;
         lat_h = (reg_height < 1) ? 1
               : (reg_height > amf_pkg::MAX_HEIGHT) ? amf_pkg::MAX_HEIGHT : reg_height;
         lat_side = (reg_window < 3) ? 3 : reg_window;
         if (lat_side % 2 == 0) lat_side--;
         lag = ((lat_side - 1) / 2) * lat_w + (lat_side - 1) / 2;
         img = new[lat_w * lat_h];
         in_frame = 1;
         in_cnt = 0;
         out_cnt = 0;
      end
      img[in_cnt] = pix;
      in_cnt++;
      if (in_cnt == lat_w * lat_h) draining = 1;
      if (out_cnt + lag < in_cnt) emit_filtered();
   endfunction

   // Result checker and receiver idling.
   always @(posedge clock) begin
      filt_px_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (filt_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected item: pixel %0d last %0b", rsp_tdata, rsp_tlast);
         end else begin
            e = filt_q.pop_front();
            if (rsp_tdata !== e.pix || rsp_tlast !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                           e.pix, e.last, rsp_tdata, rsp_tlast);
            end
         end
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 0;
      end else if (!rsp_jitter) begin
         rsp_tready <= 1;
      end else if ($urandom_range(99) < 4) begin
         rsp_hold = ($urandom_range(9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 5);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_item(logic [7:0] pix, logic flush);
      int gap;
      gap = 0;
      if (req_jitter) begin
         case ($urandom_range(9))
            0, 1, 2: gap = $urandom_range(1, 3);
            3: gap = ($urandom_range(3) == 0) ? $urandom_range(20, 80) : 0;
            default: gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= pix;
      req_tuser <= flush;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      filter_accept(pix, flush);
      items_sent++;
   endtask

   task automatic wait_drained(bit settle);
      req_tvalid <= 0;
      @(posedge clock);
      while (filt_q.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [amf_pkg::CSR_IDX_W-1:0] idx, int value);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= value[amf_pkg::CSR_W-1:0];
      case (idx)
         amf_pkg::CSR_FRAME_WIDTH: reg_width = value & 'h7FF;
         amf_pkg::CSR_FRAME_HEIGHT: reg_height = value & 'h1FFF;
         amf_pkg::CSR_MAX_WINDOW: reg_window = value & 'h7;
         default: begin
         end
      endcase
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   function automatic logic [7:0] noisy_pixel(int base);
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(255));
         default: begin
            base = base + $urandom_range(8) - 4;
            return (base < 0) ? 8'd0 : (base > 255) ? 8'd255 : base[7:0];
         end
      endcase
   endfunction

   // One frame: geometry, pixels, then flushes until the last result is out; with junk set, stray items are mixed in.
   task automatic run_frame(int w, int h, int win, bit junk);
      int base, i, npix;
      csr_write(amf_pkg::CSR_FRAME_WIDTH, w);
      csr_write(amf_pkg::CSR_FRAME_HEIGHT, h);
      csr_write(amf_pkg::CSR_MAX_WINDOW, win);
      npix = ((w & 'h7FF) < 1 ? 1 : (w & 'h7FF) > 1024 ? 1024 : (w & 'h7FF))
           * ((h & 'h1FFF) < 1 ? 1 : (h & 'h1FFF));
      base = $urandom_range(255);
      for (i = 0; i < npix; i++) begin
         if (junk && i > 0 && $urandom_range(15) == 0)
            send_item(8'($urandom_range(255)), 1'b1);
         send_item(noisy_pixel(base), 1'b0);
      end
      while (draining) begin
         if (junk && $urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b0);
         else send_item(8'($urandom_range(255)), 1'b1);
      end
      if (junk && $urandom_range(3) == 0) send_item(8'($urandom_range(255)), 1'b1);
      wait_drained(1);
   endtask

   task automatic test_directed();
      int i;
      logic [7:0] pat[12] = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd255, 8'd0,
                              8'd1, 8'd254, 8'd128, 8'd128, 8'd0, 8'd255};
      csr_write(amf_pkg::CSR_FRAME_WIDTH, 4);
      csr_write(amf_pkg::CSR_FRAME_HEIGHT, 3);
      csr_write(amf_pkg::CSR_MAX_WINDOW, 5);
      send_item(8'h55, 1'b1);
      for (i = 0; i < 12; i++) begin
         send_item(pat[i], 1'b0);
         if (i == 5) send_item(8'hAA, 1'b1);
      end
      send_item(8'hFF, 1'b0);
      while (draining) send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b1);
      wait_drained(1);
   endtask

   task automatic test_window_sizes();
      int win;
      for (win = 0; win < 8; win++) run_frame(5, 4, win, 0);
      run_frame(7, 7, 7, 1);
   endtask

   task automatic test_geometry_limits();
      csr_write(amf_pkg::CSR_FRAME_HEIGHT, 4096);
      csr_write(amf_pkg::CSR_FRAME_HEIGHT, 8191);
      run_frame(0, 0, 3, 0);
      run_frame(1, 6, 7, 0);
      run_frame(33, 1, 1, 0);
   endtask

   task automatic test_backpressure();
      int i;
      csr_write(amf_pkg::CSR_FRAME_WIDTH, 6);
      csr_write(amf_pkg::CSR_FRAME_HEIGHT, 5);
      csr_write(amf_pkg::CSR_MAX_WINDOW, 3);
      rsp_hold = 3000;
      for (i = 0; i < 30; i++) begin
         send_item(8'($urandom_range(255)), 1'b0);
         if (i == 15) wait_drained(0);
      end
      while (draining) send_item(8'h00, 1'b1);
      wait_drained(1);
   endtask

   task automatic test_random_frames();
      int win;
      while (items_sent < 1320) begin
         req_jitter = ($urandom_range(3) != 0);
         rsp_jitter = ($urandom_range(3) != 0);
         case ($urandom_range(9))
            0: win = $urandom_range(7);
            1: win = $urandom_range(5, 7);
            default: win = $urandom_range(0, 3);
         endcase
         run_frame($urandom_range(1, 12), $urandom_range(1, 9), win, 1);
      end
      req_jitter = 1;
      rsp_jitter = 1;
   endtask

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = 0;
      rsp_tready = 0;
      csr_wr_en = 0;
      csr_index = amf_pkg::CSR_FRAME_WIDTH;
      csr_wdata = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      test_directed();
      test_window_sizes();
      test_backpressure();
      test_geometry_limits();
      test_random_frames();
      if (mismatches == 0 && filt_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/amf_pkg.sv
src/amf_ctrl.sv
src/amf_dp.sv
src/adaptive_median_filter.sv
bench/adaptive_median_filter_tb.sv
